FILE: sv/vmbd_pkg.sv
// Package for the mark-byte varint decoder: payload types, codes and mark tables.
// No dependencies; every other file of the block imports it.
package vmbd_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_WIDTH_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_VALUE    = 1'b1;

  localparam logic [1:0] MODE_64 = 2'd0;
  localparam logic [1:0] MODE_32 = 2'd1;
  localparam logic [1:0] MODE_16 = 2'd2;
  localparam logic [1:0] MODE_8  = 2'd3;

  localparam logic [7:0] MARK_LAST_DIRECT = 8'd235;
  localparam logic [7:0] MARK_PAY2        = 8'd236;
  localparam logic [7:0] MARK_PAY3        = 8'd237;
  localparam logic [7:0] MARK_PAY4        = 8'd238;
  localparam logic [7:0] MARK_PAY5        = 8'd239;
  localparam logic [7:0] MARK_PAY8        = 8'd242;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_MARK = 2'd1,
    ST_TOO_WIDE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
  } vmbd_in_t;

  typedef struct packed {
    logic [63:0] decoded_value;
    status_t     status;
    logic [3:0]  encoded_length;
  } vmbd_res_t;

  // payload byte count for a multi-byte mark, zero when unsupported
  function automatic logic [3:0] payload_len(input logic [7:0] mark);
    logic [3:0] n;
    n = 4'd0;
    unique case (mark)
      MARK_PAY2: n = 4'd2;
      MARK_PAY3: n = 4'd3;
      MARK_PAY4: n = 4'd4;
      MARK_PAY5: n = 4'd5;
      MARK_PAY8: n = 4'd8;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] mode_max_payload(input logic [1:0] mode);
    logic [3:0] n;
    n = 4'd8;
    unique case (mode)
      MODE_64: n = 4'd8;
      MODE_32: n = 4'd4;
      MODE_16: n = 4'd2;
      MODE_8:  n = 4'd0;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic logic [63:0] mode_mask(input logic [1:0] mode);
    logic [63:0] m;
    m = '1;
    unique case (mode)
      MODE_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
      MODE_32: m = 64'h0000_0000_FFFF_FFFF;
      MODE_16: m = 64'h0000_0000_0000_FFFF;
      MODE_8:  m = 64'h0000_0000_0000_00FF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/vmbd_if.sv
// Valid/ready stream interfaces for the decoder's byte input and result output.
// Depends on vmbd_pkg for the payload structs.
interface vmbd_in_if import vmbd_pkg::*; ();
  logic     valid;
  logic     ready;
  vmbd_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vmbd_out_if import vmbd_pkg::*; ();
  logic      valid;
  logic      ready;
  vmbd_res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/varint_mark_byte_decoder.sv
// Mark-byte varint decoder: an accepted byte passes the input register, then the
// result register. Throughput one byte per cycle while the result is not stalled,
// set by the combinational decode step between the two registers; a stalled result
// holds the input register, so at most one further byte waits inside.
// Synchronous active-low reset: empty pipeline, waiting for a mark byte,
// mode 64-bit and fallback zero.
module varint_mark_byte_decoder import vmbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  vmbd_in_if.sink               in_if,
  vmbd_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [1:0]  mode_r;
  logic [63:0] fallback_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_64;
      fallback_r <= 64'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESULT_WIDTH_MODE: mode_r     <= cfg_wdata[1:0];
        CFG_FALLBACK_VALUE:    fallback_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register: one byte request held here
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       adv_ok;     // result register can take whatever stage 1 produces
  logic       s1_fire;    // stage 1 request is decoded this cycle

  assign adv_ok      = !out_if.valid || out_if.ready;
  assign s1_fire     = s1_valid_r && adv_ok;
  assign in_if.ready = !s1_valid_r || adv_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_byte_r <= in_if.data.data_byte;
    end
  end

  // decode step; state advances only when the request leaves stage 1
  logic      res_valid;
  vmbd_res_t res;

  vmbd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .data_byte (s1_byte_r),
    .mode      (mode_r),
    .fallback  (fallback_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register: payload bytes that finish nothing leave it empty
  logic      out_valid_r;
  vmbd_res_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_ok) begin
      out_valid_r <= s1_fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // ---- checks ----
  // a stalled result must keep its byte in stage 1
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv_ok |=> s1_valid_r && $stable(s1_byte_r))
    else $error("stage 1 request lost under back-pressure");

  // a one-byte ok result is a direct mark value
  a_direct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_OK && out_data_r.encoded_length == 4'd1
      |-> out_data_r.decoded_value <= 64'd235)
    else $error("direct value out of range");

  // an unsupported mark is reported on the mark itself
  a_bad_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_BAD_MARK |-> out_data_r.encoded_length == 4'd1)
    else $error("unsupported mark with a payload length");

  // too-wide results only follow a real payload
  a_wide_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_TOO_WIDE
      |-> out_data_r.encoded_length == 4'd3 || out_data_r.encoded_length == 4'd4 ||
          out_data_r.encoded_length == 4'd5 || out_data_r.encoded_length == 4'd6 ||
          out_data_r.encoded_length == 4'd9)
    else $error("too-wide result with an impossible length");

endmodule

FILE: sv/vmbd_step.sv
// Per-byte decode step: mark/payload state, accumulator and result forming.
// Depends on vmbd_pkg.
module vmbd_step import vmbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  data_byte,
  input  logic [1:0]  mode,
  input  logic [63:0] fallback,
  output logic        res_valid,
  output vmbd_res_t   res
);

  logic [3:0]  rem_r,  rem_nxt;
  logic [2:0]  pos_r,  pos_nxt;
  logic [63:0] acc_r,  acc_nxt;
  logic [3:0]  len_r,  len_nxt;
  logic        wide_r, wide_nxt;
  logic [3:0]  plen;
  logic [63:0] fb_masked;

  assign plen      = payload_len(data_byte);
  assign fb_masked = fallback & mode_mask(mode);

  always_comb begin
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    wide_nxt  = wide_r;
    res_valid = 1'b0;
    res       = '{decoded_value: 64'd0, status: ST_OK, encoded_length: 4'd1};
    if (rem_r == 4'd0) begin
      if (data_byte <= MARK_LAST_DIRECT) begin
        res_valid = 1'b1;
        res       = '{decoded_value: {56'd0, data_byte}, status: ST_OK,
                      encoded_length: 4'd1};
      end else if (plen == 4'd0) begin
        res_valid = 1'b1;
        res       = '{decoded_value: fb_masked, status: ST_BAD_MARK,
                      encoded_length: 4'd1};
      end else begin
        rem_nxt  = plen;
        pos_nxt  = 3'd0;
        acc_nxt  = 64'd0;
        len_nxt  = plen + 4'd1;
        wide_nxt = plen > mode_max_payload(mode);
      end
    end else begin
      // byte lanes: only the lane at the current position is written
      for (int i = 0; i < 8; i++) begin
        if (pos_r == 3'(i)) acc_nxt[i*8 +: 8] = data_byte;
      end
      pos_nxt = pos_r + 3'd1;
      rem_nxt = rem_r - 4'd1;
      if (rem_r == 4'd1) begin
        res_valid = 1'b1;
        pos_nxt   = 3'd0;
        wide_nxt  = 1'b0;
        if (wide_r) begin
          res = '{decoded_value: fb_masked, status: ST_TOO_WIDE, encoded_length: len_r};
        end else begin
          res = '{decoded_value: acc_nxt, status: ST_OK, encoded_length: len_r};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 4'd0;
      pos_r  <= 3'd0;
      acc_r  <= 64'd0;
      len_r  <= 4'd0;
      wide_r <= 1'b0;
    end else if (fire) begin
      rem_r  <= rem_nxt;
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      len_r  <= len_nxt;
      wide_r <= wide_nxt;
    end
  end

endmodule
